@@ design/rfr_pkg.sv @@
// rfr_pkg: word types, function codes and constants for the RGBA fade ramp.
// Used by the lanes, the merge stage and the top level.
package rfr_pkg;

    localparam logic [1:0] FUNC_TICK       = 2'd0;
    localparam logic [1:0] FUNC_SET        = 2'd1;
    localparam logic [1:0] FUNC_SET_FORCED = 2'd2;
    localparam logic [1:0] FUNC_UNUSED     = 2'd3;

    localparam int        NUM_CHAN  = 4;
    localparam int        FADE_FLOOR = -4;
    localparam logic [7:0] CHAN_MAX = 8'd255;

    typedef struct packed {
        logic [1:0]  func;
        logic [8:0]  dest_red;
        logic [8:0]  dest_green;
        logic [8:0]  dest_blue;
        logic [8:0]  dest_alpha;
        logic [7:0]  start_red;
        logic [7:0]  start_green;
        logic [7:0]  start_blue;
        logic [7:0]  start_alpha;
        logic [15:0] duration;
        logic [3:0]  frames_skipped;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       visible;
    } out_word_t;

    typedef struct packed {
        logic load;
        logic step;
    } lane_ctrl_t;

    typedef logic [NUM_CHAN-1:0][7:0] colour_t;

    function automatic logic [7:0] sat_chan(input logic [8:0] v);
        sat_chan = v[8] ? CHAN_MAX : v[7:0];
    endfunction

endpackage

@@ design/rfr_stream_if.sv @@
// rfr_stream_if: valid/ready channel carrying one word of a given type.
// Depends on nothing; word types come from rfr_pkg at instantiation.
interface rfr_stream_if #(parameter type word_t = logic);
    logic  valid;
    logic  ready;
    word_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ design/rfr_lane.sv @@
// rfr_lane: one colour channel; scales the start/dest difference by t and
// divides by the total tick count one quotient bit per cycle. Uses rfr_pkg.
module rfr_lane #(
    parameter int TIME_BITS = 16
) (
    input  logic                  clk,
    input  rfr_pkg::lane_ctrl_t   ctrl,
    input  logic [7:0]            start_col,
    input  logic [7:0]            dest_col,
    input  logic [TIME_BITS-1:0]  t,
    input  logic [TIME_BITS-1:0]  divisor,
    output logic [7:0]            value
);

    localparam int P = 8 + TIME_BITS;

    logic [TIME_BITS-1:0] rem_reg,  rem_next;
    logic [P-1:0]         quo_reg,  quo_next;
    logic                 neg_reg;
    logic                 neg;
    logic [7:0]           mag;
    logic [TIME_BITS:0]   rem_shift;
    logic [TIME_BITS:0]   diff;
    logic                 ge;
    logic [9:0]           sum;

    assign neg       = start_col < dest_col;
    assign mag       = neg ? (dest_col - start_col) : (start_col - dest_col);
    assign rem_shift = {rem_reg, quo_reg[P-1]};
    assign diff      = rem_shift - {1'b0, divisor};
    assign ge        = rem_shift >= {1'b0, divisor};

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        if (ctrl.load)
        begin
            rem_next = '0;
            quo_next = {{TIME_BITS{1'b0}}, mag} * {8'd0, t};
        end
        else if (ctrl.step)
        begin
            rem_next = ge ? diff[TIME_BITS-1:0] : rem_shift[TIME_BITS-1:0];
            quo_next = {quo_reg[P-2:0], ge};
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (ctrl.load)
        begin
            neg_reg <= neg;
        end
    end

    assign sum = neg_reg ? ({2'b00, dest_col} - {2'b00, quo_reg[7:0]})
                         : ({2'b00, dest_col} + {2'b00, quo_reg[7:0]});

    always_comb
    begin
        if (sum[9])
            value = 8'd0;
        else if (sum[8])
            value = rfr_pkg::CHAN_MAX;
        else
            value = sum[7:0];
    end

endmodule

@@ design/rfr_merge.sv @@
// rfr_merge: gathers the four lane values into one result word, derives the
// visible flag and holds the word in the output register. Uses rfr_pkg.
module rfr_merge (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               capture,
    input  rfr_pkg::colour_t   colour,
    output logic               can_load,
    rfr_stream_if.source       out_ch
);

    logic                 out_valid_reg, out_valid_next;
    rfr_pkg::out_word_t   out_reg;

    assign can_load = !out_valid_reg || out_ch.ready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (capture)
            out_valid_next = 1'b1;
        else if (out_ch.ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            out_reg.out_red   <= colour[0];
            out_reg.out_green <= colour[1];
            out_reg.out_blue  <= colour[2];
            out_reg.out_alpha <= colour[3];
            out_reg.visible   <= colour[3] != 8'd0;
        end
    end

    assign out_ch.valid = out_valid_reg;
    assign out_ch.data  = out_reg;

endmodule

@@ design/rgba_fade_ramp.sv @@
// rgba_fade_ramp: top level of the linear RGBA overlay fade.
// Depends on rfr_pkg, rfr_stream_if, rfr_lane and rfr_merge.
//
//   channel  | role   | word                 | handshake
//   ---------+--------+----------------------+-------------------
//   in_ch    | sink   | rfr_pkg::in_word_t   | valid/ready
//   out_ch   | source | rfr_pkg::out_word_t  | valid/ready
//
// A set word gives no result.
// A tick word forms the products when it is accepted, then runs the
// bit-serial dividers of the four lanes in ST_DIV, then loads the output
// register from ST_DONE.
// A finished tick waits in the last step while the output register is full.
// rst_n clears the fade state to a finished fade towards black.
module rgba_fade_ramp #(
    parameter int TIME_BITS = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    rfr_stream_if.sink    in_ch,
    rfr_stream_if.source  out_ch
);

    localparam int P      = 8 + TIME_BITS;
    localparam int CNT_W  = $clog2(P);
    localparam int RT_W   = TIME_BITS + 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic signed [RT_W:0] FLOOR_W = (RT_W + 1)'(rfr_pkg::FADE_FLOOR);

    logic [1:0]                  state_reg, state_next;
    logic [CNT_W-1:0]            cnt_reg,   cnt_next;
    logic signed [RT_W-1:0]      rem_ticks_reg, rem_ticks_next;
    logic [TIME_BITS-1:0]        total_reg, total_next;
    rfr_pkg::colour_t            start_reg, start_next;
    rfr_pkg::colour_t            dest_reg,  dest_next;
    rfr_pkg::colour_t            held_reg,  held_next;

    rfr_pkg::in_word_t           in_w;
    rfr_pkg::colour_t            lane_val;
    rfr_pkg::colour_t            forced_col;
    rfr_pkg::colour_t            dest_in;
    rfr_pkg::lane_ctrl_t         lane_ctrl;
    logic                        accept;
    logic                        capture;
    logic                        can_load;
    logic [TIME_BITS-1:0]        t;
    logic [TIME_BITS-1:0]        dur;
    logic signed [RT_W:0]        rem_wide;
    logic signed [RT_W:0]        dec;

    assign in_w     = in_ch.data;
    assign in_ch.ready = state_reg == ST_IDLE;
    assign accept   = in_ch.valid && in_ch.ready;

    assign forced_col = {in_w.start_alpha, in_w.start_blue, in_w.start_green, in_w.start_red};
    assign dest_in    = {rfr_pkg::sat_chan(in_w.dest_alpha), rfr_pkg::sat_chan(in_w.dest_blue),
                         rfr_pkg::sat_chan(in_w.dest_green), rfr_pkg::sat_chan(in_w.dest_red)};

    assign t   = rem_ticks_reg[RT_W-1] ? '0 : rem_ticks_reg[TIME_BITS-1:0];
    assign dur = TIME_BITS'(in_w.duration);
    assign rem_wide = $signed({rem_ticks_reg[RT_W-1], rem_ticks_reg});
    assign dec = rem_wide
               - $signed((RT_W + 1)'({1'b0, in_w.frames_skipped} + 5'd1));

    assign lane_ctrl.load = accept && (in_w.func == rfr_pkg::FUNC_TICK);
    assign lane_ctrl.step = state_reg == ST_DIV;
    assign capture        = (state_reg == ST_DONE) && can_load;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rem_ticks_next = rem_ticks_reg;
        total_next     = total_reg;
        start_next     = start_reg;
        dest_next      = dest_reg;
        held_next      = held_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    priority if (in_w.func == rfr_pkg::FUNC_TICK)
                    begin
                        cnt_next   = '0;
                        state_next = ST_DIV;
                        if (rem_wide > FLOOR_W && dec > FLOOR_W)
                            rem_ticks_next = dec[RT_W-1:0];
                        else
                            rem_ticks_next = FLOOR_W[RT_W-1:0];
                    end
                    else if (in_w.func == rfr_pkg::FUNC_SET
                             || in_w.func == rfr_pkg::FUNC_SET_FORCED)
                    begin
                        if (in_w.func == rfr_pkg::FUNC_SET_FORCED)
                        begin
                            held_next  = forced_col;
                            start_next = forced_col;
                        end
                        else
                        begin
                            start_next = held_reg;
                        end
                        dest_next      = dest_in;
                        rem_ticks_next = $signed({1'b0, dur});
                        total_next     = (dur == '0) ? TIME_BITS'(1) : dur;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(P - 1))
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (can_load)
                begin
                    held_next  = lane_val;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rem_ticks_reg <= FLOOR_W[RT_W-1:0];
            total_reg     <= TIME_BITS'(1);
            start_reg     <= '0;
            dest_reg      <= '0;
            held_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rem_ticks_reg <= rem_ticks_next;
            total_reg     <= total_next;
            start_reg     <= start_next;
            dest_reg      <= dest_next;
            held_reg      <= held_next;
        end
    end

    for (genvar c = 0; c < rfr_pkg::NUM_CHAN; c++)
    begin : g_lane
        rfr_lane #(
            .TIME_BITS (TIME_BITS)
        ) u_lane (
            .clk       (clk),
            .ctrl      (lane_ctrl),
            .start_col (start_reg[c]),
            .dest_col  (dest_reg[c]),
            .t         (t),
            .divisor   (total_reg),
            .value     (lane_val[c])
        );
    end

    rfr_merge u_merge (
        .clk      (clk),
        .rst_n    (rst_n),
        .capture  (capture),
        .colour   (lane_val),
        .can_load (can_load),
        .out_ch   (out_ch)
    );

endmodule

@@ design/rfr_checker.sv @@
// rfr_checker: port-level checks on rgba_fade_ramp, attached by bind.
// Depends on rfr_pkg for the function codes.
module rfr_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input logic [1:0] in_func,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] out_alpha,
    input logic       out_visible
);

    logic in_acc;

    assign in_acc = in_valid && in_ready;

    a_visible: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_visible == (out_alpha != 8'd0)))
        else $error("visible flag disagrees with alpha");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_alpha))
        else $error("stalled result word dropped or changed");

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && in_func == rfr_pkg::FUNC_TICK |=> !in_ready && !$rose(out_valid))
        else $error("tick word not held busy while dividing");

    a_set_silent: assert property (@(posedge clk) disable iff (!rst_n)
        in_acc && (in_func == rfr_pkg::FUNC_SET || in_func == rfr_pkg::FUNC_SET_FORCED)
        |=> !$rose(out_valid))
        else $error("set word produced a result");

endmodule

bind rgba_fade_ramp rfr_checker u_rfr_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_func     (in_ch.data.func),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_alpha   (out_ch.data.out_alpha),
    .out_visible (out_ch.data.visible)
);

@@ verif/rfr_fade_check.sv @@
// rfr_fade_check: watches both channels of rgba_fade_ramp, predicts each tick's colour
// and compares it with the word that leaves the block.
// Depends on rfr_pkg and rfr_stream_if.
module rfr_fade_check #(
    parameter int TIME_BITS = 16
) (
    input  logic   clk,
    input  logic   rst_n,
    rfr_stream_if  in_ch,
    rfr_stream_if  out_ch,
    output int     mismatches,
    output int     pending
);

    logic [7:0]          fade_from [rfr_pkg::NUM_CHAN];
    logic [7:0]          fade_to   [rfr_pkg::NUM_CHAN];
    logic [7:0]          shown     [rfr_pkg::NUM_CHAN];
    int                  ticks_left;
    int                  ticks_total;
    rfr_pkg::out_word_t  colours_due [$];

    task automatic check_field(input string name, input int exp, input int act);
        if (exp != act)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, exp, act);
            mismatches++;
        end
    endtask

    task automatic take_word(input rfr_pkg::in_word_t w);
        logic [8:0]          dest_in  [rfr_pkg::NUM_CHAN];
        logic [7:0]          start_in [rfr_pkg::NUM_CHAN];
        rfr_pkg::out_word_t  o;
        int                  t;
        int                  v;
        int                  dur;
        dest_in  = '{w.dest_red, w.dest_green, w.dest_blue, w.dest_alpha};
        start_in = '{w.start_red, w.start_green, w.start_blue, w.start_alpha};
        case (w.func)
            rfr_pkg::FUNC_TICK:
            begin
                if (ticks_left < rfr_pkg::FADE_FLOOR)
                    ticks_left = rfr_pkg::FADE_FLOOR;
                t = (ticks_left < 0) ? 0 : ticks_left;
                for (int c = 0; c < rfr_pkg::NUM_CHAN; c++)
                begin
                    v = int'(fade_to[c])
                        + ((int'(fade_from[c]) - int'(fade_to[c])) * t) / ticks_total;
                    if (v < 0)
                        v = 0;
                    if (v > int'(rfr_pkg::CHAN_MAX))
                        v = int'(rfr_pkg::CHAN_MAX);
                    shown[c] = v[7:0];
                end
                o.out_red   = shown[0];
                o.out_green = shown[1];
                o.out_blue  = shown[2];
                o.out_alpha = shown[3];
                o.visible   = (shown[3] != 8'd0);
                colours_due.push_back(o);
                if (ticks_left > rfr_pkg::FADE_FLOOR)
                begin
                    ticks_left -= int'(w.frames_skipped) + 1;
                    if (ticks_left < rfr_pkg::FADE_FLOOR)
                        ticks_left = rfr_pkg::FADE_FLOOR;
                end
                else
                    ticks_left = rfr_pkg::FADE_FLOOR;
            end
            rfr_pkg::FUNC_SET, rfr_pkg::FUNC_SET_FORCED:
            begin
                dur = int'(w.duration) & ((1 << TIME_BITS) - 1);
                for (int c = 0; c < rfr_pkg::NUM_CHAN; c++)
                begin
                    if (w.func == rfr_pkg::FUNC_SET_FORCED)
                        shown[c] = start_in[c];
                    fade_from[c] = shown[c];
                    fade_to[c]   = (dest_in[c] > 9'd255) ? rfr_pkg::CHAN_MAX : dest_in[c][7:0];
                end
                ticks_left  = dur;
                ticks_total = (dur < 1) ? 1 : dur;
            end
            default:
            begin
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rfr_pkg::out_word_t exp_w;
        rfr_pkg::out_word_t got_w;
        if (!rst_n)
        begin
            for (int c = 0; c < rfr_pkg::NUM_CHAN; c++)
            begin
                fade_from[c] = 8'd0;
                fade_to[c]   = 8'd0;
                shown[c]     = 8'd0;
            end
            ticks_left  = rfr_pkg::FADE_FLOOR;
            ticks_total = 1;
            colours_due.delete();
            pending = 0;
        end
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got_w = out_ch.data;
                if (colours_due.size() == 0)
                begin
                    $display("%0t: colour word expected none, got %h", $time, got_w);
                    mismatches++;
                end
                else
                begin
                    exp_w = colours_due.pop_front();
                    check_field("out_red",   exp_w.out_red,   got_w.out_red);
                    check_field("out_green", exp_w.out_green, got_w.out_green);
                    check_field("out_blue",  exp_w.out_blue,  got_w.out_blue);
                    check_field("out_alpha", exp_w.out_alpha, got_w.out_alpha);
                    check_field("visible",   exp_w.visible,   got_w.visible);
                end
            end
            if (in_ch.valid && in_ch.ready)
                take_word(in_ch.data);
            pending = colours_due.size();
        end
    end

endmodule

@@ verif/tb.sv @@
// tb: drives rgba_fade_ramp with directed and random fade sequences under random stalls
// and gives the verdict from the failure count of rfr_fade_check.
// Depends on rfr_pkg, rfr_stream_if, rgba_fade_ramp and rfr_fade_check.
module tb;

    localparam int WORD_TARGET = 1650;

    logic clk;
    logic rst_n;
    bit   calm;
    int   words_sent;
    int   mismatches;
    int   pending;

    rfr_stream_if #(.word_t(rfr_pkg::in_word_t))  in_ch ();
    rfr_stream_if #(.word_t(rfr_pkg::out_word_t)) out_ch ();

    rgba_fade_ramp uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch),
        .out_ch (out_ch)
    );

    rfr_fade_check chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .out_ch     (out_ch),
        .mismatches (mismatches),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    function automatic rfr_pkg::in_word_t noise_word();
        logic [95:0] raw;
        raw = {$urandom, $urandom, $urandom};
        return raw[$bits(rfr_pkg::in_word_t)-1:0];
    endfunction

    function automatic rfr_pkg::in_word_t make_word(
        input logic [1:0]  func,
        input logic [8:0]  dr, dg, db, da,
        input logic [7:0]  sr, sg, sb, sa,
        input logic [15:0] dur
    );
        rfr_pkg::in_word_t w;
        w = noise_word();
        w.func        = func;
        w.dest_red    = dr;
        w.dest_green  = dg;
        w.dest_blue   = db;
        w.dest_alpha  = da;
        w.start_red   = sr;
        w.start_green = sg;
        w.start_blue  = sb;
        w.start_alpha = sa;
        w.duration    = dur;
        return w;
    endfunction

    task automatic push_word(input rfr_pkg::in_word_t w);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= w;
        do
            @(posedge clk);
        while (!in_ch.ready);
        if (w.func != rfr_pkg::FUNC_UNUSED)
            words_sent++;
        @(negedge clk);
    endtask

    task automatic push_tick(input logic [3:0] skip);
        rfr_pkg::in_word_t w;
        w = noise_word();
        w.func           = rfr_pkg::FUNC_TICK;
        w.frames_skipped = skip;
        push_word(w);
    endtask

    initial
    begin
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (!calm && $urandom_range(0, 2) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clk);
        end
    end

    initial
    begin
        #8000000;
        $display("rgba_fade_ramp: mismatch");
        $finish;
    end

    initial
    begin
        rfr_pkg::in_word_t w;
        int                n;
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        rst_n       = 1'b0;
        calm        = 1'b0;
        words_sent  = 0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        push_tick(4'd0);
        push_word(make_word(rfr_pkg::FUNC_SET_FORCED, 9'h1FF, 9'h1FF, 9'h100, 9'h1FF,
                            8'd255, 8'd0, 8'd255, 8'd0, 16'd0));
        push_tick(4'd0);
        push_word(make_word(rfr_pkg::FUNC_SET, 9'd0, 9'd0, 9'd0, 9'd0,
                            8'd17, 8'd34, 8'd51, 8'd68, 16'hFFFF));
        push_tick(4'd15);
        push_tick(4'd15);
        push_word(make_word(rfr_pkg::FUNC_SET_FORCED, 9'd256, 9'd0, 9'd255, 9'd0,
                            8'd0, 8'd255, 8'd128, 8'd1, 16'd3));
        push_tick(4'd0);
        push_tick(4'd0);
        push_tick(4'd3);
        push_tick(4'd0);
        push_tick(4'd0);
        w = '1;
        push_word(w);
        push_tick(4'd15);
        push_word(make_word(rfr_pkg::FUNC_SET, 9'h1FF, 9'h0FF, 9'h000, 9'h101,
                            8'd0, 8'd0, 8'd0, 8'd0, 16'd1));
        push_tick(4'd15);
        push_tick(4'd0);
        push_word(make_word(rfr_pkg::FUNC_SET_FORCED, 9'd0, 9'd0, 9'd0, 9'd0,
                            8'd0, 8'd0, 8'd0, 8'd0, 16'd2));
        push_tick(4'd0);
        push_tick(4'd0);

        while (words_sent < WORD_TARGET)
        begin
            if (words_sent > WORD_TARGET - 150)
                calm = 1'b1;
            if ($urandom_range(0, 9) < 8)
            begin
                w = noise_word();
                w.func = $urandom_range(0, 1) ? rfr_pkg::FUNC_SET_FORCED : rfr_pkg::FUNC_SET;
                case ($urandom_range(0, 9))
                    0:       w.duration = 16'($urandom);
                    1, 2:    w.duration = 16'($urandom_range(0, 300));
                    default: w.duration = 16'($urandom_range(0, 40));
                endcase
                push_word(w);
                n = $urandom_range(1, 24);
                repeat (n)
                begin
                    if ($urandom_range(0, 29) == 0)
                    begin
                        w = noise_word();
                        w.func = rfr_pkg::FUNC_UNUSED;
                        push_word(w);
                    end
                    push_tick(($urandom_range(0, 3) == 0) ? 4'($urandom) : 4'd0);
                end
            end
            else
                push_word(noise_word());
        end

        in_ch.valid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
        if (mismatches == 0)
            $display("rgba_fade_ramp: match");
        else
            $display("rgba_fade_ramp: mismatch");
        $finish;
    end

endmodule

@@ sim.f @@
design/rfr_pkg.sv
design/rfr_stream_if.sv
design/rfr_lane.sv
design/rfr_merge.sv
design/rgba_fade_ramp.sv
design/rfr_checker.sv
verif/rfr_fade_check.sv
verif/tb.sv
